[rtl/core/skt_pkg.sv]
// Shared types and constants for the sorted key table.
// Used by skt_cell, skt_pick, sorted_key_table and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

  // Field widths of the item and result channels.
  localparam int OPCODE_W  = 2;
  localparam int KEY_W     = 31;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;
  localparam int INDEX_W   = 6;
  localparam int COUNT_W   = 7;

  // Default number of table entries.
  localparam int DEPTH_DEF = 64;

  // Operation codes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

  // Contents of one table entry.
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } cell_data_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                 ins_en;
    logic                 del_en;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/skt_cell.sv]
// One entry of the sorted key table: holds a key and payload, compares the key
// against the broadcast key and shifts to or from its neighbors. Uses skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 7
) (
  input  wire logic                clk,
  input  wire skt_pkg::cmd_t       cmd_i,
  input  wire logic [CNT_W-1:0]    count_i,
  input  wire logic                left_le_i,
  input  wire logic                left_eq_i,
  input  wire skt_pkg::cell_data_t left_data_i,
  input  wire skt_pkg::cell_data_t right_data_i,
  output skt_pkg::cell_data_t      data_o,
  output logic                     le_o,
  output logic                     eq_o,
  output logic                     hit_o,
  output logic                     ins_o
);

  skt_pkg::cell_data_t data_r;
  skt_pkg::cell_data_t data_nxt;
  logic                occ;
  logic                lt;

  // Compare flags; an entry at or above the count takes part in no match.
  always_comb begin
    occ   = CNT_W'(CELL_IDX) < count_i;
    eq_o  = occ && (data_r.key == cmd_i.key);
    le_o  = occ && (data_r.key <= cmd_i.key);
    lt    = le_o && !eq_o;
    // First equal entry, and the slot a new entry takes after equal keys.
    hit_o = eq_o && !left_eq_i;
    ins_o = !le_o && left_le_i;
  end

  // Insert shifts larger entries up one place; delete pulls entries from
  // the first match onward down one place.
  always_comb begin
    data_nxt = data_r;
    if (cmd_i.ins_en && !le_o) begin
      if (left_le_i) begin
        data_nxt.key     = cmd_i.key;
        data_nxt.payload = cmd_i.payload;
      end else begin
        data_nxt = left_data_i;
      end
    end else if (cmd_i.del_en && !lt) begin
      data_nxt = right_data_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

[rtl/core/skt_pick.sv]
// Turns the one-hot match and insert-slot flags of the cell row into indexes
// and selects the matched payload. Uses skt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skt_pick #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(skt_pkg::DEPTH_DEF)
) (
  input  wire logic [DEPTH-1:0]                    hit_i,
  input  wire logic [DEPTH-1:0]                    ins_i,
  input  wire skt_pkg::cell_data_t [DEPTH-1:0]     data_i,
  output logic                                     found_o,
  output logic [IDX_W-1:0]                         hit_idx_o,
  output logic [IDX_W-1:0]                         ins_idx_o,
  output logic [skt_pkg::PAYLOAD_W-1:0]            hit_payload_o
);

  // OR reductions over the one-hot flags; at most one bit of each is set.
  always_comb begin
    found_o       = |hit_i;
    hit_idx_o     = '0;
    ins_idx_o     = '0;
    hit_payload_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_i[i]) begin
        hit_idx_o     = hit_idx_o | IDX_W'(i);
        hit_payload_o = hit_payload_o | data_i[i].payload;
      end
      if (ins_i[i]) begin
        ins_idx_o = ins_idx_o | IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/sorted_key_table.sv]
// Sorted key table: top level with control, result register and cell row.
// Uses skt_pkg, skt_cell and skt_pick.
//
// The table holds up to DEPTH entries of a 31-bit key and a 32-bit payload in
// ascending key order. Each item on the in_ channel names an operation:
// search reports the first entry with an equal key, insert places the new
// entry after any equal keys, delete removes the first equal entry. Every
// item yields exactly one result on the out_ channel with a status, the
// index, the matched payload and the entry count after the operation.
// An accepted item is captured into the item registers; then every cell
// compares the broadcast key and shifts in parallel while the result
// register loads and out_valid rises. in_stall is high while an item is in
// work, so a new item is taken only after the previous one completes. If
// the previous result is still stalled on out_stall, the work waits until
// the result register is free. A synchronous reset empties the table (count
// zero) and drops any pending result; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table #(
  parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [skt_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire logic [skt_pkg::KEY_W-1:0]       in_key,
  input  wire logic [skt_pkg::PAYLOAD_W-1:0]   in_payload,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [skt_pkg::STATUS_W-1:0]         out_status,
  output logic [skt_pkg::INDEX_W-1:0]          out_index,
  output logic [skt_pkg::PAYLOAD_W-1:0]        out_found_payload,
  output logic [skt_pkg::COUNT_W-1:0]          out_entry_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                            state_r;
  skt_pkg::op_t                      op_r;
  logic [skt_pkg::KEY_W-1:0]         key_r;
  logic [skt_pkg::PAYLOAD_W-1:0]     payload_r;
  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  count_nxt;
  logic                              out_valid_r;
  logic [skt_pkg::STATUS_W-1:0]      out_status_r;
  logic [skt_pkg::INDEX_W-1:0]       out_index_r;
  logic [skt_pkg::PAYLOAD_W-1:0]     out_payload_r;
  logic [skt_pkg::COUNT_W-1:0]       out_count_r;

  logic                              fire;
  logic                              full;
  skt_pkg::cmd_t                     cmd;
  logic [skt_pkg::STATUS_W-1:0]      res_status;
  logic [IDX_W-1:0]                  res_idx;
  logic [skt_pkg::PAYLOAD_W-1:0]     res_payload;
  logic [IDX_W+skt_pkg::INDEX_W-1:0] idx_wide;
  logic [CNT_W+skt_pkg::COUNT_W-1:0] cnt_wide;

  skt_pkg::cell_data_t [DEPTH-1:0]   cell_data;
  skt_pkg::cell_data_t [DEPTH-1:0]   left_data;
  skt_pkg::cell_data_t [DEPTH-1:0]   right_data;
  logic [DEPTH-1:0]                  le_vec;
  logic [DEPTH-1:0]                  eq_vec;
  logic [DEPTH-1:0]                  left_le;
  logic [DEPTH-1:0]                  left_eq;
  logic [DEPTH-1:0]                  hit_vec;
  logic [DEPTH-1:0]                  ins_vec;
  logic                              found;
  logic [IDX_W-1:0]                  hit_idx;
  logic [IDX_W-1:0]                  ins_idx;
  logic [skt_pkg::PAYLOAD_W-1:0]     hit_payload;

  // Row of cells; each one sees its left and right neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_le[g]   = 1'b1;
      assign left_eq[g]   = 1'b0;
      assign left_data[g] = '0;
    end else begin : g_inner
      assign left_le[g]   = le_vec[g-1];
      assign left_eq[g]   = eq_vec[g-1];
      assign left_data[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_data[g] = '0;
    end else begin : g_body
      assign right_data[g] = cell_data[g+1];
    end

    skt_cell #(
      .CELL_IDX (g),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk          (clk),
      .cmd_i        (cmd),
      .count_i      (count_r),
      .left_le_i    (left_le[g]),
      .left_eq_i    (left_eq[g]),
      .left_data_i  (left_data[g]),
      .right_data_i (right_data[g]),
      .data_o       (cell_data[g]),
      .le_o         (le_vec[g]),
      .eq_o         (eq_vec[g]),
      .hit_o        (hit_vec[g]),
      .ins_o        (ins_vec[g])
    );
  end

  skt_pick #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_pick (
    .hit_i         (hit_vec),
    .ins_i         (ins_vec),
    .data_i        (cell_data),
    .found_o       (found),
    .hit_idx_o     (hit_idx),
    .ins_idx_o     (ins_idx),
    .hit_payload_o (hit_payload)
  );

  // Result of the captured item and the shift enables for the cell row.
  always_comb begin
    fire        = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);
    full        = count_r == CNT_W'(DEPTH);
    res_status  = skt_pkg::STATUS_OK;
    res_idx     = '0;
    res_payload = '0;
    count_nxt   = count_r;
    cmd.ins_en  = 1'b0;
    cmd.del_en  = 1'b0;
    cmd.key     = key_r;
    cmd.payload = payload_r;
    unique case (op_r)
      skt_pkg::OP_SEARCH: begin
        if (found) begin
          res_idx     = hit_idx;
          res_payload = hit_payload;
        end else begin
          res_status = skt_pkg::STATUS_MISSING;
        end
      end
      skt_pkg::OP_INSERT: begin
        if (full) begin
          res_status = skt_pkg::STATUS_FULL;
        end else begin
          res_idx    = ins_idx;
          count_nxt  = count_r + CNT_W'(1);
          cmd.ins_en = fire;
        end
      end
      skt_pkg::OP_DELETE: begin
        if (found) begin
          res_idx     = hit_idx;
          res_payload = hit_payload;
          count_nxt   = count_r - CNT_W'(1);
          cmd.del_en  = fire;
        end else begin
          res_status = skt_pkg::STATUS_MISSING;
        end
      end
      default: begin
        // The unused code leaves the table alone and reports ok.
      end
    endcase
    idx_wide = {{skt_pkg::INDEX_W{1'b0}}, res_idx};
    cnt_wide = {{skt_pkg::COUNT_W{1'b0}}, count_nxt};
  end

  // Control state, item capture and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r   <= ST_EXEC;
            op_r      <= skt_pkg::op_t'(in_opcode);
            key_r     <= in_key;
            payload_r <= in_payload;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (fire) begin
        count_r       <= count_nxt;
        out_valid_r   <= 1'b1;
        out_status_r  <= res_status;
        out_index_r   <= idx_wide[skt_pkg::INDEX_W-1:0];
        out_payload_r <= res_payload;
        out_count_r   <= cnt_wide[skt_pkg::COUNT_W-1:0];
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_index         = out_index_r;
  assign out_found_payload = out_payload_r;
  assign out_entry_count   = out_count_r;

  // The count never passes the table size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond table size");

  // Keys stay sorted, so at most one cell claims the first match.
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |-> $onehot0(hit_vec))
    else $error("more than one first-match cell");

  // A table with room always has exactly one insert slot.
  a_ins_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && !full) |-> $onehot(ins_vec))
    else $error("insert slot not unique");

  // An accepted item is worked on in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("accepted item not taken into work");

  // Completing an item always presents a result.
  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && (state_r == ST_IDLE))
    else $error("completed item without a result");

endmodule

`default_nettype wire

[tb/sv/sorted_key_table_tb.sv]
// Self-checking testbench for the sorted key table: directed and random items
// against a local model of the table. Depends on skt_pkg and sorted_key_table.
`timescale 1ns / 1ps

module sorted_key_table_tb;

  localparam int TBL_DEPTH   = skt_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  localparam logic [skt_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [skt_pkg::KEY_W-1:0]    KEY_MAX   = {skt_pkg::KEY_W{1'b1}};

  typedef logic [skt_pkg::KEY_W-1:0] key_t;

  typedef struct {
    logic [skt_pkg::OPCODE_W-1:0]  opcode;
    logic [skt_pkg::KEY_W-1:0]     key;
    logic [skt_pkg::PAYLOAD_W-1:0] payload;
    bit                            drain_first;
  } op_req_t;

  typedef struct packed {
    logic [skt_pkg::STATUS_W-1:0]  status;
    logic [skt_pkg::INDEX_W-1:0]   index;
    logic [skt_pkg::PAYLOAD_W-1:0] found_payload;
    logic [skt_pkg::COUNT_W-1:0]   entry_count;
  } result_t;

  // Clock, reset and block ports.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [skt_pkg::OPCODE_W-1:0] in_opcode = '0;
  logic [skt_pkg::KEY_W-1:0] in_key = '0;
  logic [skt_pkg::PAYLOAD_W-1:0] in_payload = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [skt_pkg::STATUS_W-1:0] out_status;
  logic [skt_pkg::INDEX_W-1:0] out_index;
  logic [skt_pkg::PAYLOAD_W-1:0] out_found_payload;
  logic [skt_pkg::COUNT_W-1:0] out_entry_count;

  sorted_key_table #(.DEPTH(TBL_DEPTH)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_key(in_key),
    .in_payload(in_payload),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_index(out_index),
    .out_found_payload(out_found_payload),
    .out_entry_count(out_entry_count)
  );

  // Model of the table contents, updated once per accepted item.
  logic [skt_pkg::KEY_W-1:0]     table_keys [TBL_DEPTH];
  logic [skt_pkg::PAYLOAD_W-1:0] table_payloads [TBL_DEPTH];
  int                            table_count = 0;

  op_req_t pending_ops [$];
  result_t expected_results [$];
  int      error_count = 0;
  int      idle_cycles = 0;

  // Sender pacing and receiver stall pattern.
  int  burst_left = 1;
  int  gap_left = 0;
  int  stall_run = 0;
  int  free_run = 0;
  bit  drv_busy;

  initial begin
    forever #4 clk = ~clk;
  end

  // Position of the first entry with this key, or the count if none matches.
  function automatic int find_key(input logic [skt_pkg::KEY_W-1:0] k);
    int i;
    for (i = 0; i < table_count; i++)
      if (table_keys[i] == k) return i;
    return table_count;
  endfunction

  // Apply one item to the table model and return the result it produces.
  function automatic result_t predict_table(input op_req_t rq);
    result_t r;
    int pos;
    int n;
    r = '0;
    n = table_count;
    if (rq.opcode == skt_pkg::OP_SEARCH) begin
      pos = find_key(rq.key);
      if (pos < n) begin
        r.index = pos[skt_pkg::INDEX_W-1:0];
        r.found_payload = table_payloads[pos];
      end else begin
        r.status = skt_pkg::STATUS_MISSING;
      end
    end else if (rq.opcode == skt_pkg::OP_INSERT) begin
      if (n >= TBL_DEPTH) begin
        r.status = skt_pkg::STATUS_FULL;
      end else begin
        // Equal keys stay ahead of the new entry.
        pos = n;
        while (pos > 0 && table_keys[pos-1] > rq.key) begin
          table_keys[pos] = table_keys[pos-1];
          table_payloads[pos] = table_payloads[pos-1];
          pos--;
        end
        table_keys[pos] = rq.key;
        table_payloads[pos] = rq.payload;
        r.index = pos[skt_pkg::INDEX_W-1:0];
        n++;
      end
    end else if (rq.opcode == skt_pkg::OP_DELETE) begin
      pos = find_key(rq.key);
      if (pos < n) begin
        r.index = pos[skt_pkg::INDEX_W-1:0];
        r.found_payload = table_payloads[pos];
        for (; pos + 1 < n; pos++) begin
          table_keys[pos] = table_keys[pos+1];
          table_payloads[pos] = table_payloads[pos+1];
        end
        n--;
      end else begin
        r.status = skt_pkg::STATUS_MISSING;
      end
    end
    table_count = n;
    r.entry_count = n[skt_pkg::COUNT_W-1:0];
    return r;
  endfunction

  function automatic void push_op(input logic [skt_pkg::OPCODE_W-1:0] op,
                                  input logic [skt_pkg::KEY_W-1:0] k,
                                  input logic [skt_pkg::PAYLOAD_W-1:0] pl, input bit drain);
    op_req_t rq;
    rq.opcode = op;
    rq.key = k;
    rq.payload = pl;
    rq.drain_first = drain;
    pending_ops.push_back(rq);
  endfunction

  // Stimulus: directed items first, then random phases that fill and drain.
  initial begin
    int generated;
    int phase_len;
    int phase_kind;
    int j;
    int roll;
    int key_roll;
    logic [skt_pkg::OPCODE_W-1:0] op;
    logic [skt_pkg::KEY_W-1:0] k;
    logic [31:0] rnd;

    // Empty table: misses and the unused opcode.
    push_op(skt_pkg::OP_SEARCH, 31'd5, 32'h1234_5678, 1'b0);
    push_op(skt_pkg::OP_DELETE, 31'd5, 32'h0, 1'b0);
    push_op(OP_UNUSED, 31'd9, 32'hDEAD_BEEF, 1'b0);
    // Extremes of key and payload, equal keys and a middle insert.
    push_op(skt_pkg::OP_INSERT, 31'd0, 32'h0, 1'b0);
    push_op(skt_pkg::OP_INSERT, KEY_MAX, 32'hFFFF_FFFF, 1'b0);
    push_op(skt_pkg::OP_INSERT, 31'd100, 32'hAAAA_0001, 1'b0);
    push_op(skt_pkg::OP_INSERT, 31'd100, 32'hBBBB_0002, 1'b0);
    push_op(skt_pkg::OP_INSERT, 31'd50, 32'hCCCC_0003, 1'b0);
    push_op(skt_pkg::OP_SEARCH, 31'd100, 32'h0, 1'b0);
    push_op(skt_pkg::OP_SEARCH, KEY_MAX, 32'h0, 1'b0);
    push_op(skt_pkg::OP_SEARCH, 31'd0, 32'h0, 1'b0);
    push_op(skt_pkg::OP_SEARCH, 31'd7, 32'h0, 1'b0);
    push_op(skt_pkg::OP_DELETE, 31'd100, 32'h0, 1'b0);
    push_op(skt_pkg::OP_SEARCH, 31'd100, 32'h0, 1'b0);
    // The sender waits for every result before this one.
    push_op(OP_UNUSED, KEY_MAX, 32'hFFFF_FFFF, 1'b1);
    push_op(skt_pkg::OP_DELETE, 31'd0, 32'h0, 1'b0);
    push_op(skt_pkg::OP_DELETE, KEY_MAX, 32'h0, 1'b0);
    push_op(skt_pkg::OP_DELETE, 31'd55, 32'h0, 1'b0);
    push_op(skt_pkg::OP_INSERT, 31'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    push_op(skt_pkg::OP_INSERT, 31'h2AAA_AAAA, 32'h5555_5555, 1'b0);

    // Random phases; the first one is mostly inserts, to fill the table past full.
    generated = 0;
    phase_kind = 0;
    while (generated < RANDOM_ITEMS) begin
      phase_len = (generated == 0) ? 100 : $urandom_range(40, 150);
      for (j = 0; j < phase_len; j++) begin
        roll = $urandom_range(0, 99);
        case (phase_kind)
          0: op = (roll < 80) ? skt_pkg::OP_INSERT : (roll < 90) ? skt_pkg::OP_SEARCH :
                  (roll < 98) ? skt_pkg::OP_DELETE : OP_UNUSED;
          1: op = (roll < 70) ? skt_pkg::OP_DELETE : (roll < 85) ? skt_pkg::OP_SEARCH :
                  (roll < 98) ? skt_pkg::OP_INSERT : OP_UNUSED;
          default: op = (roll < 32) ? skt_pkg::OP_INSERT :
                        (roll < 64) ? skt_pkg::OP_SEARCH :
                        (roll < 96) ? skt_pkg::OP_DELETE : OP_UNUSED;
        endcase
        // A small key pool keeps hits and duplicates frequent.
        key_roll = $urandom_range(0, 99);
        rnd = $urandom;
        if (key_roll < 60) k = key_t'($urandom_range(0, 31));
        else if (key_roll < 75) k = KEY_MAX - key_t'($urandom_range(0, 7));
        else if (key_roll < 95) k = rnd[skt_pkg::KEY_W-1:0];
        else k = rnd[0] ? KEY_MAX : '0;
        push_op(op, k, $urandom, (j == 0) && ($urandom_range(0, 2) == 0));
      end
      generated += phase_len;
      phase_kind = $urandom_range(0, 2);
    end
  end

  // Reset once, then wait for all items and results before the verdict.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_ops.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("sorted_key_table test passed");
    end else begin
      $display("sorted_key_table test failed");
    end
    $finish;
  end

  // Driver: predicts on accept and presents the next item in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drv_busy = in_valid;
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_table(pending_ops[0]));
        void'(pending_ops.pop_front());
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() == 0 ||
                     (pending_ops[0].drain_first && expected_results.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_opcode <= pending_ops[0].opcode;
          in_key <= pending_ops[0].key;
          in_payload <= pending_ops[0].payload;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver stall pattern: runs of stall and runs of free cycles.
  always @(posedge clk) begin
    if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if (free_run > 0) begin
      out_stall <= 1'b0;
      free_run <= free_run - 1;
    end else begin
      out_stall <= 1'b0;
      stall_run <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      free_run <= $urandom_range(0, 15);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_index, out_found_payload, out_entry_count};
      if (expected_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("ERROR: result with nothing expected: status %0d index %0d payload %h count %0d",
                   got.status, got.index, got.found_payload, got.entry_count);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.index !== want.index ||
            got.found_payload !== want.found_payload || got.entry_count !== want.entry_count) begin
          if (error_count < MAX_REPORTS)
            $display("ERROR: mismatch: expected status %0d index %0d payload %h count %0d",
                     want.status, want.index, want.found_payload, want.entry_count,
                     ", got status %0d index %0d payload %h count %0d",
                     got.status, got.index, got.found_payload, got.entry_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row with no item moving on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no progress for %0d cycles", IDLE_LIMIT);
      $display("sorted_key_table test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
